// ===== src/fbfs_pkg.sv =====
package fbfs_pkg;

   localparam int unsigned SIZE_W   = 32;
   localparam int unsigned POLICY_W = 2;
   localparam int unsigned ID_W     = 7;
   localparam int unsigned STATUS_W = 2;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_FIT    = 1'b1;

   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_APPENDED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_DONE
   } fbfs_state_type;

endpackage

// ===== src/fbfs_store.sv =====
module fbfs_store #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [fbfs_pkg::SIZE_W-1:0]     wr_data,
   input  logic                            rd_en,
   input  logic [AW-1:0]                   rd_addr,
   output logic [fbfs_pkg::SIZE_W-1:0]     rd_data
);

   logic [fbfs_pkg::SIZE_W-1:0] mem_ff [DEPTH];
   logic [fbfs_pkg::SIZE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fbfs_pick.sv =====
module fbfs_pick #(
   parameter int unsigned AW = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              data_valid,
   input  logic [fbfs_pkg::SIZE_W-1:0]       data,
   input  logic [AW-1:0]                     data_pos,
   input  logic [fbfs_pkg::POLICY_W-1:0]     policy,
   input  logic [fbfs_pkg::SIZE_W-1:0]       need,
   output logic                              pick_found,
   output logic [AW-1:0]                     pick_pos
);

   logic                        found_ff;
   logic                        found_in;
   logic [AW-1:0]               pos_ff;
   logic [AW-1:0]               pos_in;
   logic [fbfs_pkg::SIZE_W-1:0] size_ff;
   logic [fbfs_pkg::SIZE_W-1:0] size_in;
   logic                        fits;
   logic                        better;

   always_comb begin
      fits = (data >= need);
      case (policy)
         fbfs_pkg::POLICY_BEST: begin
            better = !found_ff || (data < size_ff);
         end
         fbfs_pkg::POLICY_WORST: begin
            better = !found_ff || (data > size_ff);
         end
         default: begin
            // first fit, also for the unused policy code
            better = !found_ff;
         end
      endcase

      found_in = found_ff;
      pos_in   = pos_ff;
      size_in  = size_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (data_valid && fits && better) begin
         found_in = 1'b1;
         pos_in   = data_pos;
         size_in  = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      size_ff <= size_in;
   end

   assign pick_found = found_ff;
   assign pick_pos   = pos_ff;

endmodule

// ===== src/free_block_fit_selector_unit.sv =====
// channel  | direction | ports
// ---------+-----------+-----------------------------------------------------
// req      | in        | req_valid, req_stall, req_kind, req_policy,
//          |           | req_request_size
// rsp      | out       | rsp_valid, rsp_stall, rsp_block_id, rsp_status
//
// One item at a time. An append or an empty-table request passes its result
// through the result register and then the output register; a fit request on
// N stored blocks first runs the one-read-per-cycle scan of the block memory.
// Reset clears the block count and control; the memory is not cleared.
// req_stall is high while an item is in work; a stalled result waits in the
// output register while the next item is already taken.
module free_block_fit_selector_unit #(
   parameter int unsigned MAX_BLOCKS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [fbfs_pkg::POLICY_W-1:0]     req_policy,
   input  logic [fbfs_pkg::SIZE_W-1:0]       req_request_size,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fbfs_pkg::ID_W-1:0]         rsp_block_id,
   output logic [fbfs_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

   function automatic logic [fbfs_pkg::ID_W-1:0] pos_to_id(input logic [CW-1:0] pos);
      logic [31:0] wide;
      wide = 32'(pos) + 32'd1;
      return wide[fbfs_pkg::ID_W-1:0];
   endfunction

   fbfs_pkg::fbfs_state_type state_ff, state_in;

   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   rd_idx_ff, rd_idx_in;
   logic                            rd_pend_ff;
   logic [AW-1:0]                   rd_pos_ff;
   logic [fbfs_pkg::POLICY_W-1:0]   policy_ff, policy_in;
   logic [fbfs_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic [fbfs_pkg::ID_W-1:0]       res_id_ff, res_id_in;
   logic [fbfs_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fbfs_pkg::ID_W-1:0]       rsp_block_id_ff, rsp_block_id_in;
   logic [fbfs_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                            accept;
   logic                            full;
   logic                            rsp_load;
   logic                            mem_wr_en;
   logic [fbfs_pkg::SIZE_W-1:0]     mem_wr_data;
   logic                            mem_rd_en;
   logic [fbfs_pkg::SIZE_W-1:0]     mem_rd_data;
   logic                            pick_clear;
   logic                            pick_found;
   logic [AW-1:0]                   pick_pos;

   fbfs_store #(
      .DEPTH (MAX_BLOCKS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   fbfs_pick #(
      .AW (AW)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .clear      (pick_clear),
      .data_valid (rd_pend_ff),
      .data       (mem_rd_data),
      .data_pos   (rd_pos_ff),
      .policy     (policy_ff),
      .need       (size_ff),
      .pick_found (pick_found),
      .pick_pos   (pick_pos)
   );

   assign req_stall = (state_ff != fbfs_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(MAX_BLOCKS));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rd_idx_in       = rd_idx_ff;
      policy_in       = policy_ff;
      size_in         = size_ff;
      res_id_in       = res_id_ff;
      res_status_in   = res_status_ff;
      mem_wr_en       = 1'b0;
      mem_wr_data     = size_ff;
      mem_rd_en       = 1'b0;
      pick_clear      = 1'b0;
      rsp_load        = 1'b0;

      case (state_ff)
         fbfs_pkg::ST_IDLE: begin
            if (accept) begin
               policy_in  = req_policy;
               size_in    = req_request_size;
               rd_idx_in  = '0;
               pick_clear = 1'b1;
               if (req_kind == fbfs_pkg::KIND_APPEND) begin
                  if (full) begin
                     res_id_in     = '0;
                     res_status_in = fbfs_pkg::STATUS_FULL;
                  end else begin
                     mem_wr_en     = 1'b1;
                     mem_wr_data   = req_request_size;
                     count_in      = count_ff + CW'(1);
                     res_id_in     = pos_to_id(count_ff);
                     res_status_in = fbfs_pkg::STATUS_APPENDED;
                  end
                  state_in = fbfs_pkg::ST_DONE;
               end else if (count_ff == '0) begin
                  res_id_in     = '0;
                  res_status_in = fbfs_pkg::STATUS_EMPTY;
                  state_in      = fbfs_pkg::ST_DONE;
               end else begin
                  state_in = fbfs_pkg::ST_SCAN;
               end
            end
         end
         fbfs_pkg::ST_SCAN: begin
            if (rd_idx_ff != count_ff) begin
               mem_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
            end else if (!rd_pend_ff) begin
               // last read data has been folded into the pick
               state_in = fbfs_pkg::ST_FINISH;
            end
         end
         fbfs_pkg::ST_FINISH: begin
            if (pick_found) begin
               res_id_in     = pos_to_id(CW'(pick_pos));
               res_status_in = fbfs_pkg::STATUS_FOUND;
            end else if (full) begin
               res_id_in     = '0;
               res_status_in = fbfs_pkg::STATUS_FULL;
            end else begin
               mem_wr_en     = 1'b1;
               count_in      = count_ff + CW'(1);
               res_id_in     = pos_to_id(count_ff);
               res_status_in = fbfs_pkg::STATUS_APPENDED;
            end
            state_in = fbfs_pkg::ST_DONE;
         end
         fbfs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = fbfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbfs_pkg::ST_IDLE;
         end
      endcase

      rsp_block_id_in = rsp_block_id_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_valid_in    = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_block_id_in = res_id_ff;
         rsp_status_in   = res_status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbfs_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= mem_rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff       <= rd_idx_in;
      rd_pos_ff       <= rd_idx_ff[AW-1:0];
      policy_ff       <= policy_in;
      size_ff         <= size_in;
      res_id_ff       <= res_id_in;
      res_status_ff   <= res_status_in;
      rsp_block_id_ff <= rsp_block_id_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_block_id = rsp_block_id_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1750;
   localparam int TAIL_CYCLES  = 80;

   // policy code with no meaning of its own; the block treats it as first fit
   localparam logic [fbfs_pkg::POLICY_W-1:0] POLICY_SPARE = 2'd3;

   typedef struct packed {
      logic                          kind;
      logic [fbfs_pkg::POLICY_W-1:0] policy;
      logic [fbfs_pkg::SIZE_W-1:0]   size;
   } fit_req_type;

   typedef struct packed {
      logic [fbfs_pkg::ID_W-1:0]     block_id;
      logic [fbfs_pkg::STATUS_W-1:0] status;
   } grant_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic                          req_kind         = fbfs_pkg::KIND_APPEND;
   logic [fbfs_pkg::POLICY_W-1:0] req_policy       = fbfs_pkg::POLICY_FIRST;
   logic [fbfs_pkg::SIZE_W-1:0]   req_request_size = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic [fbfs_pkg::ID_W-1:0]     rsp_block_id;
   logic [fbfs_pkg::STATUS_W-1:0] rsp_status;

   // shadow of the block's free table
   logic [fbfs_pkg::SIZE_W-1:0] free_sizes [TABLE_DEPTH];
   int                          free_count = 0;

   fit_req_type pending_items[$];
   grant_type   expected_grants[$];

   int          items_queued   = 0;
   int          items_sent     = 0;
   int          mismatch_count = 0;
   int          send_gap       = 0;
   int          send_calm      = 0;
   int          stall_left     = 0;
   int          stall_calm     = 0;
   logic        req_fire       = 1'b0;
   fit_req_type next_item;
   grant_type   seen;

   free_block_fit_selector_unit #(
      .MAX_BLOCKS(TABLE_DEPTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_policy      (req_policy),
      .req_request_size(req_request_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_block_id    (rsp_block_id),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("FAIL free_block_fit_selector_unit");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // mostly back to back, some short gaps, a few long ones, now and then a calm stretch
   function automatic int idle_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 2) begin
         calm = $urandom_range(40, 160);
         return 0;
      end
      if (r < 110) return 0;
      if (r < 185) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic predict_grant(input logic kind,
                                input logic [fbfs_pkg::POLICY_W-1:0] pol,
                                input logic [fbfs_pkg::SIZE_W-1:0] need);
      grant_type                   g;
      int                          i;
      int                          pick;
      logic [fbfs_pkg::SIZE_W-1:0] pick_size;
      g         = '0;
      pick      = 0;
      pick_size = '0;
      if (kind == fbfs_pkg::KIND_FIT && free_count == 0) begin
         g.status = fbfs_pkg::STATUS_EMPTY;
      end else begin
         if (kind == fbfs_pkg::KIND_FIT) begin
            for (i = 0; i < free_count; i++) begin
               if (free_sizes[i] < need) continue;
               if (pol == fbfs_pkg::POLICY_BEST) begin
                  if (pick == 0 || free_sizes[i] < pick_size) begin
                     pick      = i + 1;
                     pick_size = free_sizes[i];
                  end
               end else if (pol == fbfs_pkg::POLICY_WORST) begin
                  if (pick == 0 || free_sizes[i] > pick_size) begin
                     pick      = i + 1;
                     pick_size = free_sizes[i];
                  end
               end else if (pick == 0) begin
                  pick = i + 1;
               end
            end
         end
         if (pick != 0) begin
            g.block_id = fbfs_pkg::ID_W'(pick);
            g.status   = fbfs_pkg::STATUS_FOUND;
         end else if (free_count >= TABLE_DEPTH) begin
            g.status = fbfs_pkg::STATUS_FULL;
         end else begin
            free_sizes[free_count] = need;
            free_count++;
            g.block_id = fbfs_pkg::ID_W'(free_count);
            g.status   = fbfs_pkg::STATUS_APPENDED;
         end
      end
      expected_grants.push_back(g);
   endtask

   // input side: drive at the falling edge, hold the payload until the transfer
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_items.size() > 0) begin
            next_item         = pending_items.pop_front();
            req_valid        <= 1'b1;
            req_kind         <= next_item.kind;
            req_policy       <= next_item.policy;
            req_request_size <= next_item.size;
            send_gap          = idle_len(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_len(stall_calm);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            predict_grant(req_kind, req_policy, req_request_size);
            items_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_grants.size() == 0) begin
               flag_mismatch($sformatf("unexpected result: id %0d status %0d",
                                       rsp_block_id, rsp_status));
            end else begin
               seen = expected_grants.pop_front();
               if (rsp_block_id !== seen.block_id)
                  flag_mismatch($sformatf("block_id %0d, expected %0d",
                                          rsp_block_id, seen.block_id));
               if (rsp_status !== seen.status)
                  flag_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_status, seen.status));
            end
         end
      end
   end

   // stimulus steps just after the rising edge, clear of both driver and monitor
   task automatic next_slot();
      @(posedge clock);
      #1;
   endtask

   task automatic queue_item(input logic kind,
                             input logic [fbfs_pkg::POLICY_W-1:0] pol,
                             input logic [fbfs_pkg::SIZE_W-1:0] size);
      fit_req_type it;
      while (pending_items.size() >= 3) next_slot();
      it.kind   = kind;
      it.policy = pol;
      it.size   = size;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic wait_settled();
      while (items_sent != items_queued || expected_grants.size() != 0) next_slot();
   endtask

   function automatic logic [fbfs_pkg::SIZE_W-1:0] fresh_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return {1'b1, {(fbfs_pkg::SIZE_W-1){1'b0}}};
         3, 4, 5: return $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   // request sizes near the stored ones, so most requests land on a block
   function automatic logic [fbfs_pkg::SIZE_W-1:0] fitting_size();
      logic [fbfs_pkg::SIZE_W-1:0] s;
      if (free_count == 0) return fresh_size();
      s = free_sizes[$urandom_range(0, free_count - 1)];
      case ($urandom_range(0, 5))
         0, 1:    return s;
         2:       return s >> $urandom_range(1, 12);
         3:       return s - $urandom_range(0, 3);
         4:       return s + 1;
         default: return $urandom_range(0, 15);
      endcase
   endfunction

   initial begin
      int                            n;
      logic [fbfs_pkg::POLICY_W-1:0] pol;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table under every policy
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_FIRST, 32'd5);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_BEST, 32'd0);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_WORST, 32'hFFFF_FFFF);
      queue_item(fbfs_pkg::KIND_FIT, POLICY_SPARE, 32'd7);

      // policy is don't-care on an append
      queue_item(fbfs_pkg::KIND_APPEND, POLICY_SPARE, 32'd0);
      queue_item(fbfs_pkg::KIND_APPEND, fbfs_pkg::POLICY_FIRST, 32'd100);
      queue_item(fbfs_pkg::KIND_APPEND, fbfs_pkg::POLICY_WORST, 32'd100);
      queue_item(fbfs_pkg::KIND_APPEND, fbfs_pkg::POLICY_BEST, 32'd50);
      queue_item(fbfs_pkg::KIND_APPEND, fbfs_pkg::POLICY_FIRST, 32'h8000_0000);

      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_FIRST, 32'd0);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_BEST, 32'd100);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_BEST, 32'd60);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_BEST, 32'd1);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_WORST, 32'd1);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_BEST, 32'h8000_0000);
      queue_item(fbfs_pkg::KIND_FIT, POLICY_SPARE, 32'd51);

      // misses append; worst fit has to reach the last entry; ties go to the earliest
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_WORST, 32'h8000_0001);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_FIRST, 32'hFFFF_FFFF);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_WORST, 32'd0);
      queue_item(fbfs_pkg::KIND_APPEND, fbfs_pkg::POLICY_BEST, 32'hFFFF_FFFF);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_WORST, 32'd5);
      queue_item(fbfs_pkg::KIND_FIT, fbfs_pkg::POLICY_BEST, 32'hFFFF_FFFF);

      wait_settled();

      // table fills up part way through, then full-table behavior takes over
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_settled();
         if ($urandom_range(0, 9) == 0)
            pol = POLICY_SPARE;
         else
            pol = fbfs_pkg::POLICY_W'($urandom_range(0, 2));
         if ($urandom_range(0, 99) < 4)
            queue_item(fbfs_pkg::KIND_APPEND, pol, fresh_size());
         else if ($urandom_range(0, 9) == 0)
            queue_item(fbfs_pkg::KIND_FIT, pol, fresh_size());
         else
            queue_item(fbfs_pkg::KIND_FIT, pol, fitting_size());
      end

      wait_settled();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS free_block_fit_selector_unit");
      else
         $display("FAIL free_block_fit_selector_unit");
      $finish;
   end

endmodule
